/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the glyph layout block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, clocked on clk and switched off while reset is asserted.
`define STGL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Same-cycle implication.
`define STGL_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/stgl_pkg.sv */
// Shared types, constants and decode functions of the glyph layout block.
// No dependencies; the front, queue, back and top-level files import this package.
package stgl_pkg;

	localparam int SHEET_COLUMNS = 94;

	// decoupling queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// configuration register indexes
	localparam logic REG_LINE_LIMIT   = 1'b0;
	localparam logic REG_NEWLINE_CODE = 1'b1;

	localparam logic [7:0] LIMIT_RESET   = 8'd128;
	localparam logic [7:0] NEWLINE_RESET = 8'd36;
	localparam logic [7:0] LIMIT_MIN     = 8'd8;
	localparam logic [7:0] LIMIT_MAX     = 8'd128;
	localparam logic [7:0] GLYPH_ADV     = 8'd8;
	localparam logic [7:0] SPACE_ADV     = 8'd4;

	// input command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TEXT  = 1'b1;

	// result kinds
	localparam logic KIND_GLYPH = 1'b0;
	localparam logic KIND_END   = 1'b1;

	// character classes
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] LEAD1_LO  = 8'h81;
	localparam logic [7:0] LEAD1_HI  = 8'h9F;
	localparam logic [7:0] LEAD2_LO  = 8'hE0;
	localparam logic [7:0] LEAD2_HI  = 8'hFC;
	localparam logic [7:0] TRAIL_LO  = 8'h40;
	localparam logic [7:0] TRAIL_HI  = 8'hFC;

	// glyph index bases for single-byte characters (two sheet rows in)
	localparam int IDX_W = 15;
	localparam logic [IDX_W-1:0] IDX_DIGIT = IDX_W'(SHEET_COLUMNS * 2 + 16);
	localparam logic [IDX_W-1:0] IDX_UPPER = IDX_W'(SHEET_COLUMNS * 2 + 33);
	localparam logic [IDX_W-1:0] IDX_LOWER = IDX_W'(SHEET_COLUMNS * 2 + 65);

	// two-byte code boundaries
	localparam logic [15:0] SJ_ROW84   = 16'h8440;
	localparam logic [15:0] SJ_ROW83   = 16'h8340;
	localparam logic [15:0] SJ_ROW83_H = 16'h837F;
	localparam logic [15:0] SJ_ROW82_H = 16'h8280;
	localparam logic [15:0] SJ_ROW82   = 16'h8240;
	localparam logic [15:0] SJ_ROW81_H = 16'h817F;
	localparam logic [15:0] SJ_ROW81   = 16'h8140;

	// divide by the sheet width: q = (idx * DIV_MULT) >> DIV_SHIFT, exact below 2**15
	localparam int DIV_SHIFT = 22;
	localparam logic [15:0] DIV_MULT = 16'((2 ** DIV_SHIFT + SHEET_COLUMNS - 1) / SHEET_COLUMNS);
	localparam int QUO_W = 9;
	localparam int REM_W = 7;

	// back-end operation codes
	localparam logic [2:0] OP_START   = 3'd0;
	localparam logic [2:0] OP_NEWLINE = 3'd1;
	localparam logic [2:0] OP_SPACE   = 3'd2;
	localparam logic [2:0] OP_LEAD    = 3'd3;
	localparam logic [2:0] OP_GLYPH   = 3'd4;
	localparam logic [2:0] OP_END     = 3'd5;

	typedef struct packed {
		logic [2:0]       op;
		logic             wrap;  // run the line wrap test first
		logic [IDX_W-1:0] idx;
		logic [6:0]       sx;
		logic [15:0]      sy;
	} stgl_op_t;

	function automatic logic [7:0] eff_limit(input logic [7:0] lim);
		if (lim < LIMIT_MIN) return LIMIT_MIN;
		if (lim > LIMIT_MAX) return LIMIT_MAX;
		return lim;
	endfunction

	function automatic logic [15:0] add8_sat(input logic [15:0] y);
		logic [16:0] s;
		s = {1'b0, y} + 17'(GLYPH_ADV);
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic logic [IDX_W-1:0] pair_index(input logic [7:0] lead,
			input logic [7:0] trail);
		logic [15:0] code;
		logic [16:0] v;
		code = {lead, trail};
		if (code >= SJ_ROW84)
			v = {1'b0, code - SJ_ROW84} + 17'(16 * 36);
		else if (code >= SJ_ROW83_H)
			v = {1'b0, code - SJ_ROW83} + 17'(16 * 24 - 8);
		else if (code >= SJ_ROW83)
			v = {1'b0, code - SJ_ROW83} + 17'(16 * 24 - 7);
		else if (code >= SJ_ROW82_H)
			v = {1'b0, code - SJ_ROW82} + 17'(16 * 12 - 4);
		else if (code >= SJ_ROW82)
			v = {1'b0, code - SJ_ROW82} + 17'(16 * 12 - 3);
		else if (code >= SJ_ROW81_H)
			v = {1'b0, code - SJ_ROW81};
		else
			v = {1'b0, code - SJ_ROW81} + 17'd1;
		return v[IDX_W-1:0];
	endfunction

endpackage

/* rtl/stgl_item_if.sv */
// Input channel of the glyph layout block: valid/ready plus one text item.
// Depends on nothing.
interface stgl_item_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  text_byte;
	logic [6:0]  start_x;
	logic [15:0] start_y;

	modport source(output valid, cmd, text_byte, start_x, start_y, input ready);
	modport sink(input valid, cmd, text_byte, start_x, start_y, output ready);
endinterface

/* rtl/stgl_result_if.sv */
// Output channel of the glyph layout block: valid/ready plus one placement result.
// Depends on nothing.
interface stgl_result_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [6:0]         dest_x;
	logic [15:0]        dest_y;
	logic signed [10:0] src_x;
	logic [11:0]        src_y;

	modport source(output valid, kind, dest_x, dest_y, src_x, src_y, input ready);
	modport sink(input valid, kind, dest_x, dest_y, src_x, src_y, output ready);
endinterface

/* rtl/stgl_front.sv */
// Front end: accepts text items, tracks string and lead-byte state, classifies each byte.
// Depends on stgl_pkg and stgl_item_if.
module stgl_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         line_limit,
	input  logic [7:0]         newline_code,
	stgl_item_if.sink          item,
	output logic               push_valid,
	input  logic               push_ready,
	output stgl_pkg::stgl_op_t push_op
);
	import stgl_pkg::*;

	logic       active_q;
	logic       lead_pending_q;
	logic [7:0] held_lead_q;
	logic       active_d;
	logic       lead_pending_d;
	logic [7:0] held_lead_d;

	logic [7:0] lim;
	logic [7:0] room;
	logic [6:0] sx_clamped;
	logic [7:0] c;
	logic       is_digit, is_upper, is_lower, is_lead, trail_ok;
	logic       accepted;

	assign lim        = eff_limit(line_limit);
	assign room       = lim - GLYPH_ADV;
	assign sx_clamped = ({1'b0, item.start_x} > room) ? room[6:0] : item.start_x;

	assign c        = item.text_byte;
	assign is_digit = (c >= CH_0) && (c <= CH_9);
	assign is_upper = (c >= CH_UA) && (c <= CH_UZ);
	assign is_lower = (c >= CH_LA) && (c <= CH_LZ);
	assign is_lead  = ((c >= LEAD1_LO) && (c <= LEAD1_HI)) ||
		((c >= LEAD2_LO) && (c <= LEAD2_HI));
	assign trail_ok = (c >= TRAIL_LO) && (c <= TRAIL_HI);

	assign item.ready = push_ready;
	assign accepted   = item.valid && push_ready;
	// text while no string is open is consumed without a queue entry
	assign push_valid = item.valid && ((item.cmd == CMD_START) || active_q);

	always_comb begin
		push_op        = '0;
		push_op.op     = OP_END;
		push_op.sx     = sx_clamped;
		push_op.sy     = item.start_y;
		active_d       = active_q;
		lead_pending_d = lead_pending_q;
		held_lead_d    = held_lead_q;
		if (item.cmd == CMD_START) begin
			push_op.op     = OP_START;
			active_d       = 1'b1;
			lead_pending_d = 1'b0;
			held_lead_d    = '0;
		end else if (active_q) begin
			if (lead_pending_q) begin
				lead_pending_d = 1'b0;
				held_lead_d    = '0;
				if (trail_ok) begin
					push_op.op  = OP_GLYPH;
					push_op.idx = pair_index(held_lead_q, c);
				end else begin
					push_op.op = OP_END;
					active_d   = 1'b0;
				end
			end else if (c == newline_code) begin
				push_op.op = OP_NEWLINE;
			end else begin
				push_op.wrap = 1'b1;
				if (c == CH_SPACE) begin
					push_op.op = OP_SPACE;
				end else if (is_digit) begin
					push_op.op  = OP_GLYPH;
					push_op.idx = IDX_DIGIT + {7'd0, c - CH_0};
				end else if (is_upper) begin
					push_op.op  = OP_GLYPH;
					push_op.idx = IDX_UPPER + {7'd0, c - CH_UA};
				end else if (is_lower) begin
					push_op.op  = OP_GLYPH;
					push_op.idx = IDX_LOWER + {7'd0, c - CH_LA};
				end else if (is_lead) begin
					push_op.op     = OP_LEAD;
					lead_pending_d = 1'b1;
					held_lead_d    = c;
				end else begin
					push_op.op = OP_END;
					active_d   = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			lead_pending_q <= 1'b0;
			held_lead_q    <= '0;
		end else if (accepted) begin
			active_q       <= active_d;
			lead_pending_q <= lead_pending_d;
			held_lead_q    <= held_lead_d;
		end
	end

endmodule

/* rtl/stgl_queue.sv */
// Short FIFO of classified operations between front and back end.
// Depends on stgl_pkg.
module stgl_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  stgl_pkg::stgl_op_t push_op,
	output logic               pop_valid,
	input  logic               pop_ready,
	output stgl_pkg::stgl_op_t pop_op
);
	import stgl_pkg::*;

	stgl_op_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_op     = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/stgl_back.sv */
// Back end: owns the cursor, applies wrap/newline/advance, forms results in an output register.
// Depends on stgl_pkg and stgl_result_if.
module stgl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         line_limit,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  stgl_pkg::stgl_op_t pop_op,
	stgl_result_if.source      result
);
	import stgl_pkg::*;

	logic [7:0]  cursor_x_q;
	logic [15:0] cursor_y_q;
	logic [6:0]  line_start_q;

	logic               out_valid_q;
	logic               kind_q;
	logic [6:0]         dest_x_q;
	logic [15:0]        dest_y_q;
	logic signed [10:0] src_x_q;
	logic [11:0]        src_y_q;

	logic [7:0]  lim;
	logic        makes_result, out_free, fire, do_wrap;
	logic [7:0]  x0;
	logic [15:0] y0;

	// sheet row/column of the glyph
	logic [IDX_W+15:0]  prod;
	logic [QUO_W-1:0]   quo;
	logic [IDX_W-1:0]   quo_ext, quo94, rem_full;
	logic [REM_W-1:0]   rem;
	logic signed [10:0] sx_sheet;
	logic [11:0]        sy_sheet;

	assign lim          = eff_limit(line_limit);
	assign makes_result = (pop_op.op == OP_GLYPH) || (pop_op.op == OP_END);
	assign out_free     = !out_valid_q || result.ready;
	assign pop_ready    = !makes_result || out_free;
	assign fire         = pop_valid && pop_ready;

	assign do_wrap = pop_op.wrap && (({1'b0, cursor_x_q} + 9'(GLYPH_ADV)) > {1'b0, lim});
	assign x0      = do_wrap ? {1'b0, line_start_q} : cursor_x_q;
	assign y0      = do_wrap ? add8_sat(cursor_y_q) : cursor_y_q;

	assign prod     = {16'd0, pop_op.idx} * {{IDX_W{1'b0}}, DIV_MULT};
	assign quo      = prod[DIV_SHIFT +: QUO_W];
	assign quo_ext  = IDX_W'(quo);
	assign quo94    = (quo_ext << 6) + (quo_ext << 5) - (quo_ext << 1);
	assign rem_full = pop_op.idx - quo94;
	assign rem      = rem_full[REM_W-1:0];
	assign sx_sheet = ($signed({4'd0, rem}) - 11'sd1) <<< 3;
	assign sy_sheet = {quo, 3'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			line_start_q <= '0;
		end else if (fire) begin
			case (pop_op.op)
				OP_START: begin
					line_start_q <= pop_op.sx;
					cursor_x_q   <= {1'b0, pop_op.sx};
					cursor_y_q   <= pop_op.sy;
				end
				OP_NEWLINE: begin
					cursor_x_q <= {1'b0, line_start_q};
					cursor_y_q <= add8_sat(cursor_y_q);
				end
				OP_SPACE: begin
					cursor_x_q <= x0 + SPACE_ADV;
					cursor_y_q <= y0;
				end
				OP_GLYPH: begin
					cursor_x_q <= x0 + GLYPH_ADV;
					cursor_y_q <= y0;
				end
				default: begin
					cursor_x_q <= x0;
					cursor_y_q <= y0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire && makes_result)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire && makes_result) begin
			dest_y_q <= y0;
			if (pop_op.op == OP_GLYPH) begin
				kind_q   <= KIND_GLYPH;
				dest_x_q <= x0[6:0];
				src_x_q  <= sx_sheet;
				src_y_q  <= sy_sheet;
			end else begin
				kind_q   <= KIND_END;
				dest_x_q <= '0;
				src_x_q  <= '0;
				src_y_q  <= '0;
			end
		end
	end

	assign result.valid  = out_valid_q;
	assign result.kind   = kind_q;
	assign result.dest_x = dest_x_q;
	assign result.dest_y = dest_y_q;
	assign result.src_x  = src_x_q;
	assign result.src_y  = src_y_q;

endmodule

/* rtl/sjis_text_glyph_layout_core.sv */
// Shift-JIS/ASCII text glyph layout for an 8x8 font sheet, top level.
// An item's operation is written into a queue entry when the item transfers; the back
// end then pops it and loads the result into the output register.
// Throughput: one item per cycle when the queue has room and the result is not stalled.
// Reset (arst_n low, asynchronous): queue empty, no string open, cursor at zero,
// line_limit 128 and newline_code 36.
module sjis_text_glyph_layout_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [7:0]    cfg_data,
	stgl_item_if.sink     item,
	stgl_result_if.source result
);
	import stgl_pkg::*;

	// Configuration registers. The user must write them only while the block is idle;
	// the block does not enforce this. The front and back read them live, no shadow copy.
	logic [7:0] line_limit_q;
	logic [7:0] newline_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q   <= LIMIT_RESET;
			newline_code_q <= NEWLINE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_LIMIT:   line_limit_q   <= cfg_data;
				REG_NEWLINE_CODE: newline_code_q <= cfg_data;
				default:          line_limit_q   <= line_limit_q;
			endcase
		end
	end

	// Front -> queue: one classified operation per transfer. The front keeps the
	// string-open and held-lead state, which depends only on the byte stream, so
	// classification never waits on the cursor.
	logic     fq_valid, fq_ready;
	stgl_op_t fq_op;

	// Queue -> back: the back pops non-result ops freely and result ops only
	// when the output register is free or being emptied.
	logic     qb_valid, qb_ready;
	stgl_op_t qb_op;

	stgl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.line_limit   (line_limit_q),
		.newline_code (newline_code_q),
		.item         (item),
		.push_valid   (fq_valid),
		.push_ready   (fq_ready),
		.push_op      (fq_op)
	);

	stgl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_op    (fq_op),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_op     (qb_op)
	);

	// Back end: wrap test, cursor update, divide-by-sheet-width and the
	// registered result, which holds while the downstream stalls.
	stgl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_limit (line_limit_q),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_op     (qb_op),
		.result     (result)
	);

endmodule

/* rtl/stgl_checker.sv */
// Port-level checks on the result channel of the glyph layout block, and its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module stgl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               out_kind,
	input logic [6:0]         out_dest_x,
	input logic [15:0]        out_dest_y,
	input logic signed [10:0] out_src_x,
	input logic [11:0]        out_src_y
);
	`STGL_ASSERT(a_stall_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_kind) && $stable(out_dest_y)), "result changed while stalled")
	`STGL_ASSERT_IMP(a_end_zero, out_valid && out_kind, (out_dest_x == 7'd0) && (out_src_x == 11'sd0) && (out_src_y == 12'd0), "end result carries glyph fields")
	`STGL_ASSERT_IMP(a_glyph_align, out_valid && !out_kind, (out_src_x[2:0] == 3'd0) && (out_src_y[2:0] == 3'd0), "sheet position not on 8-pixel grid")
	`STGL_ASSERT_IMP(a_glyph_range, out_valid && !out_kind, (out_src_x >= -11'sd8) && (out_src_x <= 11'sd736) && (out_src_y <= 12'd2680), "sheet position out of range")
endmodule

bind sjis_text_glyph_layout_core stgl_checker u_stgl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_kind   (result.kind),
	.out_dest_x (result.dest_x),
	.out_dest_y (result.dest_y),
	.out_src_x  (result.src_x),
	.out_src_y  (result.src_y)
);
